>>> src/ba_pkg.sv
`default_nettype none
package ba_pkg;

  localparam int MEMORY_ORDER = 16;
  localparam int HEADER_BYTES = 32;
  localparam int MIN_ORDER    = 6;

  localparam int TOP_LEVEL  = MEMORY_ORDER - MIN_ORDER;
  localparam int NUM_BLOCKS = 1 << TOP_LEVEL;
  localparam int HEAD_N     = TOP_LEVEL + 1;
  localparam int BLK_W      = TOP_LEVEL;
  localparam int LINK_W     = TOP_LEVEL + 1;
  localparam int LVL_W      = $clog2(TOP_LEVEL + 1);
  localparam int ADDR_W     = 16;

  // null link sits one past the last block
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_BLOCKS);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_IGNORED  = 2'd2
  } status_t;

  // one block record in the state memory
  typedef struct packed {
    logic              alloc;
    logic [LVL_W-1:0]  ord;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] next;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef struct packed {
    logic             en;
    logic             we;
    logic [BLK_W-1:0] addr;
    ent_t             wdata;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] address;
    status_t           status;
  } result_t;

endpackage
`default_nettype wire

>>> src/ba_ifs.sv
`default_nettype none
interface ba_in_if;
  import ba_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] request_bytes;
  logic [ADDR_W-1:0] free_address;
  modport source (output valid, output command, output request_bytes,
                  output free_address, input ready);
  modport sink   (input valid, input command, input request_bytes,
                  input free_address, output ready);
  modport monitor (input valid, input command, input request_bytes,
                   input free_address, input ready);
endinterface

interface ba_out_if;
  import ba_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_address;
  logic [1:0]        status;
  modport source (output valid, output result_address, output status, input ready);
  modport sink   (input valid, input result_address, input status, output ready);
  modport monitor (input valid, input result_address, input status, input ready);
endinterface
`default_nettype wire

>>> src/ba_ram.sv
`default_nettype none
module ba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

>>> src/ba_ctrl.sv
`default_nettype none
module ba_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  ba_in_if.sink                          in_ch,
  output ba_pkg::result_t                res,
  input  wire logic                      res_ready,
  output ba_pkg::ram_req_t               ram_req,
  input  wire logic [ba_pkg::ENT_W-1:0]  ram_rdata
);
  import ba_pkg::*;

  typedef enum logic [21:0] {
    S_CLR       = 22'h000001,
    S_IDLE      = 22'h000002,
    S_A_POP_RD  = 22'h000004,
    S_A_POP_CHK = 22'h000008,
    S_A_NX_RD   = 22'h000010,
    S_A_NX_WR   = 22'h000020,
    S_A_SPL_WB  = 22'h000040,
    S_A_SPL_WH  = 22'h000080,
    S_A_FIN_WB  = 22'h000100,
    S_F_RD      = 22'h000200,
    S_F_CHK     = 22'h000400,
    S_F_TEST    = 22'h000800,
    S_F_BUD_CHK = 22'h001000,
    S_F_NX_RD   = 22'h002000,
    S_F_NX_WR   = 22'h004000,
    S_F_PV_RD   = 22'h008000,
    S_F_PV_WR   = 22'h010000,
    S_F_BUD_WR  = 22'h020000,
    S_F_PUSH_WB = 22'h040000,
    S_F_H_RD    = 22'h080000,
    S_F_H_WR    = 22'h100000,
    S_DONE      = 22'h200000
  } state_t;

  state_t            state;
  logic [LINK_W-1:0] heads [HEAD_N];
  logic [BLK_W-1:0]  clr_cnt;
  logic [BLK_W-1:0]  b;
  logic [BLK_W-1:0]  bud;
  logic [LINK_W-1:0] nx;
  logic [LINK_W-1:0] pv;
  logic [LVL_W-1:0]  lvl;
  logic [LVL_W-1:0]  k;
  logic              bw_alloc;
  logic [LVL_W-1:0]  bw_ord;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;

  ent_t              rd;
  logic [ADDR_W:0]   total;
  logic              oversize;
  logic [LVL_W-1:0]  k_c;
  logic [LVL_W-1:0]  j_c;
  logic              found;
  logic [ADDR_W-1:0] off;
  logic              bad_free;
  logic [BLK_W-1:0]  b_c;
  logic [BLK_W-1:0]  half;
  logic [BLK_W-1:0]  bud_c;
  logic [LINK_W-1:0] head_cur;
  logic [ADDR_W-1:0] alloc_addr;

  assign rd       = ent_t'(ram_rdata);
  assign head_cur = heads[lvl];
  assign half     = b + (BLK_W'(1) << lvl);
  assign bud_c    = b ^ (BLK_W'(1) << lvl);
  assign alloc_addr = ADDR_W'((ADDR_W + MEMORY_ORDER)'(b) << MIN_ORDER)
                    + ADDR_W'(HEADER_BYTES);

  // request sizing, free-list search and free-address check
  always_comb begin
    total    = (ADDR_W + 1)'(in_ch.request_bytes) + (ADDR_W + 1)'(HEADER_BYTES);
    oversize = 64'(total) >= (64'(1) << MEMORY_ORDER);
    k_c      = LVL_W'(TOP_LEVEL);
    for (int l = TOP_LEVEL; l >= 0; l--) begin
      if ((64'(1) << (l + MIN_ORDER)) >= 64'(total)) k_c = LVL_W'(l);
    end
    j_c   = k_c;
    found = 1'b0;
    for (int l = TOP_LEVEL; l >= 0; l--) begin
      if (LVL_W'(l) >= k_c && heads[l] != NULL_LINK) begin
        j_c   = LVL_W'(l);
        found = 1'b1;
      end
    end
    off      = in_ch.free_address - ADDR_W'(HEADER_BYTES);
    b_c      = BLK_W'(off >> MIN_ORDER);
    bad_free = (in_ch.free_address == '0)
            || (32'(in_ch.free_address) < HEADER_BYTES)
            || ((off & ADDR_W'((1 << MIN_ORDER) - 1)) != '0)
            || ((32'(off) >> MIN_ORDER) >= NUM_BLOCKS);
  end

  // memory port, one access per cycle
  always_comb begin
    ram_req = '0;
    unique case (state)
      S_CLR: begin
        ram_req.en    = 1'b1;
        ram_req.we    = 1'b1;
        ram_req.addr  = clr_cnt;
        ram_req.wdata = '{alloc: 1'b0,
                          ord: (clr_cnt == '0) ? LVL_W'(TOP_LEVEL) : '0,
                          prev: NULL_LINK, next: NULL_LINK};
      end
      S_A_POP_RD: begin
        ram_req.en   = 1'b1;
        ram_req.addr = head_cur[BLK_W-1:0];
      end
      S_A_NX_RD, S_F_NX_RD, S_F_H_RD: begin
        ram_req.en   = 1'b1;
        ram_req.addr = nx[BLK_W-1:0];
      end
      S_A_NX_WR: begin
        ram_req.en         = 1'b1;
        ram_req.we         = 1'b1;
        ram_req.addr       = nx[BLK_W-1:0];
        ram_req.wdata      = rd;
        ram_req.wdata.prev = NULL_LINK;
      end
      S_A_SPL_WB: begin
        ram_req.en    = 1'b1;
        ram_req.we    = 1'b1;
        ram_req.addr  = b;
        ram_req.wdata = '{alloc: 1'b0, ord: lvl, prev: NULL_LINK, next: {1'b0, half}};
      end
      S_A_SPL_WH: begin
        ram_req.en    = 1'b1;
        ram_req.we    = 1'b1;
        ram_req.addr  = half;
        ram_req.wdata = '{alloc: 1'b0, ord: lvl, prev: {1'b0, b}, next: NULL_LINK};
      end
      S_A_FIN_WB: begin
        ram_req.en    = 1'b1;
        ram_req.we    = 1'b1;
        ram_req.addr  = b;
        ram_req.wdata = '{alloc: 1'b1, ord: k, prev: NULL_LINK, next: NULL_LINK};
      end
      S_F_RD: begin
        ram_req.en   = 1'b1;
        ram_req.addr = b;
      end
      S_F_TEST: begin
        ram_req.en   = (32'(lvl) < TOP_LEVEL);
        ram_req.addr = bud_c;
      end
      S_F_NX_WR: begin
        ram_req.en         = 1'b1;
        ram_req.we         = 1'b1;
        ram_req.addr       = nx[BLK_W-1:0];
        ram_req.wdata      = rd;
        ram_req.wdata.prev = pv;
      end
      S_F_PV_RD: begin
        ram_req.en   = 1'b1;
        ram_req.addr = pv[BLK_W-1:0];
      end
      S_F_PV_WR: begin
        ram_req.en         = 1'b1;
        ram_req.we         = 1'b1;
        ram_req.addr       = pv[BLK_W-1:0];
        ram_req.wdata      = rd;
        ram_req.wdata.next = nx;
      end
      S_F_BUD_WR: begin
        ram_req.en    = 1'b1;
        ram_req.we    = 1'b1;
        ram_req.addr  = bud;
        ram_req.wdata = '{alloc: bw_alloc, ord: bw_ord, prev: NULL_LINK, next: NULL_LINK};
      end
      S_F_PUSH_WB: begin
        ram_req.en    = 1'b1;
        ram_req.we    = 1'b1;
        ram_req.addr  = b;
        ram_req.wdata = '{alloc: 1'b0, ord: lvl, prev: NULL_LINK, next: head_cur};
      end
      S_F_H_WR: begin
        ram_req.en         = 1'b1;
        ram_req.we         = 1'b1;
        ram_req.addr       = nx[BLK_W-1:0];
        ram_req.wdata      = rd;
        ram_req.wdata.prev = {1'b0, b};
      end
      default: ram_req = '0;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);
  assign res.valid   = (state == S_DONE);
  assign res.address = res_addr;
  assign res.status  = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      for (int l = 0; l < HEAD_N; l++) begin
        heads[l] <= (l == TOP_LEVEL) ? '0 : NULL_LINK;
      end
    end else begin
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + BLK_W'(1);
          if (clr_cnt == BLK_W'(NUM_BLOCKS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            res_addr <= '0;
            if (in_ch.command == CMD_ALLOC) begin
              if (oversize || !found) begin
                res_status <= ST_NO_SPACE;
                state      <= S_DONE;
              end else begin
                k     <= k_c;
                lvl   <= j_c;
                state <= S_A_POP_RD;
              end
            end else begin
              if (bad_free) begin
                res_status <= ST_IGNORED;
                state      <= S_DONE;
              end else begin
                b     <= b_c;
                state <= S_F_RD;
              end
            end
          end
        end
        S_A_POP_RD: begin
          b     <= head_cur[BLK_W-1:0];
          state <= S_A_POP_CHK;
        end
        S_A_POP_CHK: begin
          nx         <= rd.next;
          heads[lvl] <= rd.next;
          if (rd.next != NULL_LINK) begin
            state <= S_A_NX_RD;
          end else if (lvl > k) begin
            lvl   <= lvl - LVL_W'(1);
            state <= S_A_SPL_WB;
          end else begin
            state <= S_A_FIN_WB;
          end
        end
        S_A_NX_RD: state <= S_A_NX_WR;
        S_A_NX_WR: begin
          if (lvl > k) begin
            lvl   <= lvl - LVL_W'(1);
            state <= S_A_SPL_WB;
          end else begin
            state <= S_A_FIN_WB;
          end
        end
        S_A_SPL_WB: state <= S_A_SPL_WH;
        S_A_SPL_WH: begin
          heads[lvl] <= {1'b0, b};
          state      <= S_A_POP_RD;
        end
        S_A_FIN_WB: begin
          res_addr   <= alloc_addr;
          res_status <= ST_DONE;
          state      <= S_DONE;
        end
        S_F_RD: state <= S_F_CHK;
        S_F_CHK: begin
          if (!rd.alloc) begin
            res_status <= ST_IGNORED;
            state      <= S_DONE;
          end else begin
            lvl   <= (32'(rd.ord) > TOP_LEVEL) ? LVL_W'(TOP_LEVEL) : rd.ord;
            state <= S_F_TEST;
          end
        end
        S_F_TEST: begin
          bud <= bud_c;
          if (32'(lvl) < TOP_LEVEL) state <= S_F_BUD_CHK;
          else state <= S_F_PUSH_WB;
        end
        S_F_BUD_CHK: begin
          bw_alloc <= rd.alloc;
          bw_ord   <= rd.ord;
          nx       <= rd.next;
          pv       <= rd.prev;
          if (rd.alloc || rd.ord != lvl) begin
            state <= S_F_PUSH_WB;
          end else begin
            if (head_cur == {1'b0, bud}) heads[lvl] <= rd.next;
            if (rd.next != NULL_LINK) state <= S_F_NX_RD;
            else if (rd.prev != NULL_LINK) state <= S_F_PV_RD;
            else state <= S_F_BUD_WR;
          end
        end
        S_F_NX_RD: state <= S_F_NX_WR;
        S_F_NX_WR: state <= (pv != NULL_LINK) ? S_F_PV_RD : S_F_BUD_WR;
        S_F_PV_RD: state <= S_F_PV_WR;
        S_F_PV_WR: state <= S_F_BUD_WR;
        S_F_BUD_WR: begin
          if (bud < b) b <= bud;
          lvl   <= lvl + LVL_W'(1);
          state <= S_F_TEST;
        end
        S_F_PUSH_WB: begin
          heads[lvl] <= {1'b0, b};
          nx         <= head_cur;
          res_status <= ST_DONE;
          state      <= (head_cur != NULL_LINK) ? S_F_H_RD : S_DONE;
        end
        S_F_H_RD: state <= S_F_H_WR;
        S_F_H_WR: state <= S_DONE;
        S_DONE: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clr_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !in_ch.ready)
    else $error("item taken during clearing pass");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res_ready) |=> (res.valid && $stable(res.status)
                                   && $stable(res.address)))
    else $error("result dropped before taken");

  a_merge_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_F_BUD_CHK) |-> (32'(lvl) < TOP_LEVEL))
    else $error("merge above top level");

  a_split_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_SPL_WB) |-> (lvl >= k))
    else $error("split below requested level");

endmodule
`default_nettype wire

>>> src/buddy_allocator_top.sv
`default_nettype none
// channel  dir  payload                          handshake
// in_ch    in   command, request_bytes,          valid/ready
//               free_address
// out_ch   out  result_address, status           valid/ready
//
// after reset a clearing pass writes every one of the 1024 block records;
// no item is taken until it ends
// each split level and each merge level walks the block records through
// the single port of the block memory, one access at a time
// one item is in work at a time
// a finished result sits in the output register, and the next item is
// taken while it waits
module buddy_allocator_top (
  input  wire logic clk,
  input  wire logic rst,
  ba_in_if.sink     in_ch,
  ba_out_if.source  out_ch
);
  import ba_pkg::*;

  result_t            res;
  logic               res_ready;
  ram_req_t           ram_req;
  logic [ENT_W-1:0]   ram_rdata;
  logic               out_valid;
  logic [ADDR_W-1:0]  out_addr;
  logic [1:0]         out_status;

  // sequencer over the block records and free-list heads
  ba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .res       (res),
    .res_ready (res_ready),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // block records: links, order and allocated flag per block
  ba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_BLOCKS)
  ) u_blk_ram (
    .clk   (clk),
    .en    (ram_req.en),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  // output register decouples the sequencer from the sink
  assign res_ready = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_addr   <= res.address;
      out_status <= res.status;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.result_address = out_addr;
  assign out_ch.status         = out_status;

endmodule
`default_nettype wire
